[rtl/quaternion_to_euler_angles_macros.svh]
// Assertion macros for the quaternion to Euler angles block
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Check a condition at every clock edge outside reset
`define Q2E_ASSERT_NOW(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("q2e check failed");

// Check that a condition in one cycle implies another in the next cycle
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("q2e check failed");

`endif

[rtl/q2e_pkg.sv]
// Shared types, widths and constants for the quaternion to Euler angles block
`default_nettype none

package q2e_pkg;

   // Width of the yaw, roll and pitch vector terms (signed)
   localparam int TERM_W = 37;
   // Pitch arcsine argument after scaling, and the square root result
   localparam int ROOT_W = 31;
   // Radicand of the pitch cosine leg
   localparam int PROD_W = 62;
   // CORDIC vector width after normalization
   localparam int WW = 45;
   // Angle accumulator width, degrees * 2^16
   localparam int ZW = 27;
   // Bit position that normalization brings the larger leg up to
   localparam int NORM_BIT = 40;
   localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

   // Arctangent table, atan(2^-i) in degrees * 2^16
   localparam int ATAN_ROM_LEN = 24;
   localparam logic [21:0] ATAN_ROM [ATAN_ROM_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
      22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
      22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
   };

   // Output limits
   localparam int YAW_W = 15;
   localparam int PITCH_W = 14;
   localparam int HALF_TURN = 11520;
   localparam int QUARTER_TURN = 5760;

   // Front end result handed to the square root and the angle units
   typedef struct packed {
      logic signed [TERM_W-1:0] yaw_x;
      logic signed [TERM_W-1:0] yaw_y;
      logic signed [TERM_W-1:0] roll_x;
      logic signed [TERM_W-1:0] roll_y;
      logic [ROOT_W-1:0]        mag;
      logic                     neg;
      logic                     err;
      logic [PROD_W-1:0]        prod;
   } q2e_prep_type;

endpackage

`default_nettype wire

[rtl/q2e_if.sv]
// Request and response channel interfaces
`default_nettype none

interface q2e_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] q_real;
   logic signed [15:0] q_i;
   logic signed [15:0] q_j;
   logic signed [15:0] q_k;

   modport source (output valid, output q_real, output q_i, output q_j, output q_k,
                   input ready);
   modport sink (input valid, input q_real, input q_i, input q_j, input q_k,
                 output ready);
endinterface

interface q2e_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] yaw_deg;
   logic signed [13:0] pitch_deg;
   logic signed [14:0] roll_deg;
   logic               domain_error;

   modport source (output valid, output yaw_deg, output pitch_deg, output roll_deg,
                   output domain_error, input ready);
   modport sink (input valid, input yaw_deg, input pitch_deg, input roll_deg,
                 input domain_error, output ready);
endinterface

`default_nettype wire

[rtl/q2e_prep.sv]
// Front end: products, vector terms, pitch argument scaling and cosine radicand
`default_nettype none

module q2e_prep
   import q2e_pkg::*;
#(
   parameter int COMPONENT_WIDTH = 16
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [15:0]  raw_real,
   input  wire logic [15:0]  raw_i,
   input  wire logic [15:0]  raw_j,
   input  wire logic [15:0]  raw_k,
   output q2e_prep_type      prep_out
);

   localparam int SH = (COMPONENT_WIDTH > 16) ? 0 : 17 - COMPONENT_WIDTH;

   // Take the low component bits as two's complement (zero extended when COMPONENT_WIDTH > 16)
   function automatic logic signed [16:0] comp(input logic [15:0] raw);
      logic signed [16:0] ext;
      ext = (COMPONENT_WIDTH > 16) ? $signed({1'b0, raw}) : $signed({raw[15], raw});
      comp = (ext <<< SH) >>> SH;
   endfunction

   logic signed [16:0] cr, ci, cj, ck;
   logic signed [33:0] p_rr_ff, p_ii_ff, p_jj_ff, p_kk_ff, p_ij_ff;
   logic signed [33:0] p_kr_ff, p_jk_ff, p_ir_ff, p_jr_ff, p_ik_ff;
   logic signed [TERM_W-1:0] yaw_x_ff, yaw_y_ff, roll_x_ff, roll_y_ff, s_ff;
   logic [33:0] n_ff;
   logic [TERM_W-1:0] a_in;
   logic [33:0] ac_in;
   logic over_in;
   logic [1:0] sh_in;
   logic [ROOT_W-1:0] n3_ff;
   q2e_prep_type st3_ff, st4_ff, st5_ff;
   q2e_prep_type st5_in;
   logic [ROOT_W-1:0] dif_ff;
   logic [ROOT_W:0]   sum_ff;

   assign cr = comp(raw_real);
   assign ci = comp(raw_i);
   assign cj = comp(raw_j);
   assign ck = comp(raw_k);

   // Stage 1: component products
   always_ff @(posedge clock) begin
      if (en) begin
         p_rr_ff <= cr * cr;
         p_ii_ff <= ci * ci;
         p_jj_ff <= cj * cj;
         p_kk_ff <= ck * ck;
         p_ij_ff <= ci * cj;
         p_kr_ff <= ck * cr;
         p_jk_ff <= cj * ck;
         p_ir_ff <= ci * cr;
         p_jr_ff <= cj * cr;
         p_ik_ff <= ci * ck;
      end
   end

   // Stage 2: vector terms, pitch numerator and squared norm
   always_ff @(posedge clock) begin
      if (en) begin
         yaw_y_ff  <= (TERM_W'(p_ij_ff) + TERM_W'(p_kr_ff)) <<< 1;
         yaw_x_ff  <= TERM_W'(p_ii_ff) - TERM_W'(p_jj_ff) - TERM_W'(p_kk_ff)
                      + TERM_W'(p_rr_ff);
         roll_y_ff <= (TERM_W'(p_jk_ff) + TERM_W'(p_ir_ff)) <<< 1;
         roll_x_ff <= TERM_W'(p_kk_ff) + TERM_W'(p_rr_ff) - TERM_W'(p_ii_ff)
                      - TERM_W'(p_jj_ff);
         s_ff      <= (TERM_W'(p_jr_ff) - TERM_W'(p_ik_ff)) <<< 1;
         n_ff      <= $unsigned(p_ii_ff) + $unsigned(p_jj_ff) + $unsigned(p_kk_ff)
                      + $unsigned(p_rr_ff);
      end
   end

   // Stage 3: clamp the argument and scale both below 2^31
   always_comb begin
      a_in    = s_ff[TERM_W-1] ? $unsigned(-s_ff) : $unsigned(s_ff);
      over_in = a_in > TERM_W'(n_ff);
      ac_in   = over_in ? n_ff : a_in[33:0];
      priority if (n_ff[33]) sh_in = 2'd3;
      else if (n_ff[32])     sh_in = 2'd2;
      else if (n_ff[31])     sh_in = 2'd1;
      else                   sh_in = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st3_ff.yaw_x  <= yaw_x_ff;
         st3_ff.yaw_y  <= yaw_y_ff;
         st3_ff.roll_x <= roll_x_ff;
         st3_ff.roll_y <= roll_y_ff;
         st3_ff.mag    <= ROOT_W'(ac_in >> sh_in);
         st3_ff.neg    <= s_ff[TERM_W-1];
         st3_ff.err    <= (n_ff == '0) || over_in;
         st3_ff.prod   <= '0;
         n3_ff         <= ROOT_W'(n_ff >> sh_in);
      end
   end

   // Stage 4: difference and sum of the scaled norm and argument
   always_ff @(posedge clock) begin
      if (en) begin
         st4_ff <= st3_ff;
         dif_ff <= n3_ff - st3_ff.mag;
         sum_ff <= {1'b0, n3_ff} + {1'b0, st3_ff.mag};
      end
   end

   // Stage 5: cosine leg radicand
   always_comb begin
      st5_in      = st4_ff;
      st5_in.prod = PROD_W'(dif_ff) * PROD_W'(sum_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st5_ff <= st5_in;
      end
   end

   assign prep_out = st5_ff;

endmodule

`default_nettype wire

[rtl/q2e_isqrt.sv]
// Pipelined integer square root, one result bit per stage
`default_nettype none

module q2e_isqrt
   import q2e_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [PROD_W-1:0] radicand,
   output logic      [ROOT_W-1:0] root
);

   localparam int STAGES = ROOT_W;

   logic [PROD_W-1:0] v_ff [STAGES];
   logic [PROD_W-1:0] r_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (2 * (STAGES - 1 - g));
      logic [PROD_W-1:0] v_prev, r_prev, trial;

      if (g == 0) begin : g_first
         assign v_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[g-1];
         assign r_prev = r_ff[g-1];
      end

      assign trial = r_prev + BIT;

      // Subtract the trial value when it fits and set this root bit
      always_ff @(posedge clock) begin
         if (en) begin
            if (v_prev >= trial) begin
               v_ff[g] <= v_prev - trial;
               r_ff[g] <= (r_prev >> 1) + BIT;
            end else begin
               v_ff[g] <= v_prev;
               r_ff[g] <= r_prev >> 1;
            end
         end
      end
   end

   assign root = r_ff[STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

[rtl/q2e_cordic.sv]
// Pipelined vectoring CORDIC: four-quadrant angle in degrees * 64
`default_nettype none

module q2e_cordic
   import q2e_pkg::*;
#(
   parameter int STEPS = 16,
   parameter int OUT_W = 15,
   parameter int LIM   = 11520
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic signed [TERM_W-1:0] vec_x,
   input  wire logic signed [TERM_W-1:0] vec_y,
   output logic signed [OUT_W-1:0]       angle
);

   localparam int ITER = (STEPS < ATAN_ROM_LEN) ? STEPS : ATAN_ROM_LEN;
   localparam int AW = TERM_W + 1;
   localparam int RW = ZW - 10;

   logic signed [AW-1:0] xe, ye, xa_in, ya_in, yabs_in;
   logic [AW-1:0] m_in;
   logic signed [ZW-1:0] z0_in;

   logic signed [AW-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [AW-1:0] m0_ff;
   logic signed [ZW-1:0] z0_ff, z1_ff;
   logic zero0_ff, zero1_ff;
   logic [5:0] k_in, k1_ff;

   logic signed [WW-1:0] xp_ff [ITER+1];
   logic signed [WW-1:0] yp_ff [ITER+1];
   logic signed [ZW-1:0] zp_ff [ITER+1];
   logic                 zp_zero_ff [ITER+1];

   logic signed [ZW-1:0] zf_in;
   logic signed [RW-1:0] r_in;

   // Stage 0: fold the left half plane over and take the larger leg
   always_comb begin
      xe      = AW'(vec_x);
      ye      = AW'(vec_y);
      xa_in   = vec_x[TERM_W-1] ? -xe : xe;
      ya_in   = vec_x[TERM_W-1] ? -ye : ye;
      yabs_in = ya_in[AW-1] ? -ya_in : ya_in;
      m_in    = ($unsigned(xa_in) > $unsigned(yabs_in)) ? $unsigned(xa_in)
                                                       : $unsigned(yabs_in);
      if (vec_x[TERM_W-1]) begin
         z0_in = vec_y[TERM_W-1] ? -DEG180 : DEG180;
      end else begin
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff    <= xa_in;
         y0_ff    <= ya_in;
         z0_ff    <= z0_in;
         m0_ff    <= m_in;
         zero0_ff <= (m_in == '0);
      end
   end

   // Stage 1: find the normalizing shift from the leading one
   always_comb begin
      k_in = '0;
      for (int b = 0; b < AW; b++) begin
         if (m0_ff[b]) begin
            k_in = 6'(NORM_BIT - b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x0_ff;
         y1_ff    <= y0_ff;
         z1_ff    <= z0_ff;
         zero1_ff <= zero0_ff;
         k1_ff    <= k_in;
      end
   end

   // Stage 2: normalize the vector
   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff[0]      <= WW'(x1_ff) <<< k1_ff;
         yp_ff[0]      <= WW'(y1_ff) <<< k1_ff;
         zp_ff[0]      <= z1_ff;
         zp_zero_ff[0] <= zero1_ff;
      end
   end

   // Rotation stages, one per table entry used (the first ITER entries)
   for (genvar j = 0; j < ITER; j++) begin : g_iter
      localparam logic signed [ZW-1:0] ROT = $signed(ZW'(ATAN_ROM[j]));
      logic signed [WW-1:0] dx, dy;

      assign dx = yp_ff[j] >>> j;
      assign dy = xp_ff[j] >>> j;

      always_ff @(posedge clock) begin
         if (en) begin
            zp_zero_ff[j+1] <= zp_zero_ff[j];
            if (!yp_ff[j][WW-1]) begin
               xp_ff[j+1] <= xp_ff[j] + dx;
               yp_ff[j+1] <= yp_ff[j] - dy;
               zp_ff[j+1] <= zp_ff[j] + ROT;
            end else begin
               xp_ff[j+1] <= xp_ff[j] - dx;
               yp_ff[j+1] <= yp_ff[j] + dy;
               zp_ff[j+1] <= zp_ff[j] - ROT;
            end
         end
      end
   end

   // Output stage: round to degrees * 64 and saturate
   always_comb begin
      zf_in = zp_zero_ff[ITER] ? '0 : zp_ff[ITER];
      r_in  = RW'((zf_in + ZW'(512)) >>> 10);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         priority if (r_in > RW'(LIM)) begin
            angle <= OUT_W'(LIM);
         end else if (r_in < -RW'(LIM)) begin
            angle <= -OUT_W'(LIM);
         end else begin
            angle <= OUT_W'(r_in);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/quaternion_to_euler_angles.sv]
// The pipeline runs through the front end, then the square root, then the angle units.
// Throughput: one quaternion per cycle unless a held result stalls; every stage moves together on a shared enable.
// A held result stalls the whole pipeline until it is taken; bubbles are not squeezed out.
// The valid bits travel in registers beside the data; the pitch path sets the depth.
// Reset (synchronous, active high) clears the valid bits; no result is in flight after it.
`default_nettype none

`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles
   import q2e_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int COMPONENT_WIDTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   q2e_req_if.sink    req_ch,
   q2e_rsp_if.source  rsp_ch
);

   localparam int ITER     = (CORDIC_STEPS < ATAN_ROM_LEN) ? CORDIC_STEPS : ATAN_ROM_LEN;
   localparam int PREP_LAT = 5;
   localparam int ROOT_LAT = ROOT_W;
   localparam int CORD_LAT = ITER + 4;
   localparam int TOTAL    = PREP_LAT + ROOT_LAT + CORD_LAT;

   logic en;
   logic [TOTAL-1:0] vld_ff;
   q2e_prep_type prep_s;
   q2e_prep_type side_ff [ROOT_LAT];
   logic [ROOT_W-1:0] root;
   logic err_ff [CORD_LAT];
   logic signed [TERM_W-1:0] mag_s, pitch_x, pitch_y;
   logic signed [YAW_W-1:0] yaw_a, roll_a;
   logic signed [PITCH_W-1:0] pitch_a;
   logic pitch_in_range, yaw_in_range, roll_in_range;

   // Advance everything unless a finished result is held
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   // Valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], req_ch.valid};
      end
   end

   q2e_prep #(
      .COMPONENT_WIDTH(COMPONENT_WIDTH)
   ) u_prep (
      .clock    (clock),
      .en       (en),
      .raw_real (req_ch.q_real),
      .raw_i    (req_ch.q_i),
      .raw_j    (req_ch.q_j),
      .raw_k    (req_ch.q_k),
      .prep_out (prep_s)
   );

   q2e_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (prep_s.prod),
      .root     (root)
   );

   // Hold the other terms alongside the square root
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= prep_s;
         for (int i = 1; i < ROOT_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign mag_s   = $signed(TERM_W'(side_ff[ROOT_LAT-1].mag));
   assign pitch_y = side_ff[ROOT_LAT-1].neg ? -mag_s : mag_s;
   assign pitch_x = $signed(TERM_W'(root));

   q2e_cordic #(
      .STEPS(CORDIC_STEPS), .OUT_W(YAW_W), .LIM(HALF_TURN)
   ) u_yaw (
      .clock (clock),
      .en    (en),
      .vec_x (side_ff[ROOT_LAT-1].yaw_x),
      .vec_y (side_ff[ROOT_LAT-1].yaw_y),
      .angle (yaw_a)
   );

   q2e_cordic #(
      .STEPS(CORDIC_STEPS), .OUT_W(YAW_W), .LIM(HALF_TURN)
   ) u_roll (
      .clock (clock),
      .en    (en),
      .vec_x (side_ff[ROOT_LAT-1].roll_x),
      .vec_y (side_ff[ROOT_LAT-1].roll_y),
      .angle (roll_a)
   );

   q2e_cordic #(
      .STEPS(CORDIC_STEPS), .OUT_W(PITCH_W), .LIM(QUARTER_TURN)
   ) u_pitch (
      .clock (clock),
      .en    (en),
      .vec_x (pitch_x),
      .vec_y (pitch_y),
      .angle (pitch_a)
   );

   // Carry the error flag through the angle units
   always_ff @(posedge clock) begin
      if (en) begin
         err_ff[0] <= side_ff[ROOT_LAT-1].err;
         for (int i = 1; i < CORD_LAT; i++) begin
            err_ff[i] <= err_ff[i-1];
         end
      end
   end

   assign rsp_ch.valid        = vld_ff[TOTAL-1];
   assign rsp_ch.yaw_deg      = yaw_a;
   assign rsp_ch.roll_deg     = roll_a;
   assign rsp_ch.pitch_deg    = pitch_a;
   assign rsp_ch.domain_error = err_ff[CORD_LAT-1];

   // Range checks on the output angles
   assign pitch_in_range = (pitch_a <= QUARTER_TURN) && (pitch_a >= -QUARTER_TURN);
   assign yaw_in_range   = (yaw_a <= HALF_TURN) && (yaw_a >= -HALF_TURN);
   assign roll_in_range  = (roll_a <= HALF_TURN) && (roll_a >= -HALF_TURN);

   // An accepted request enters the first valid bit
   `Q2E_ASSERT_NEXT(a_accept_enters, req_ch.valid && req_ch.ready, vld_ff[0])
   // Pitch stays within a quarter turn
   `Q2E_ASSERT_NOW(a_pitch_range, !rsp_ch.valid || pitch_in_range)
   // Yaw and roll stay within a half turn
   `Q2E_ASSERT_NOW(a_turn_range, !rsp_ch.valid || (yaw_in_range && roll_in_range))

endmodule

`default_nettype wire
